>>> src/apfls_pkg.sv
// ----------------------------------------------------------------------------
// apfls_pkg
// Shared widths, segment constants and the score scaling for the pollution
// scorer.
// ----------------------------------------------------------------------------
package apfls_pkg;

    // Field widths
    localparam int PM_W      = 14;
    localparam int VOC_W     = 13;
    localparam int TEMP_W    = 12;
    localparam int RH_W      = 11;
    localparam int CUR_W     = 15;
    localparam int SLOPE_W   = 16;
    localparam int FAN_W     = 3;
    localparam int CLASS_W   = 2;
    localparam int ANOM_W    = 2;
    localparam int SCORE_OUT_W = 15;

    // Score scaling
    localparam int SCORE_FRAC_BITS = 8;
    localparam int SCORE_W   = SCORE_FRAC_BITS + 7;     // holds 100 << frac

    // Accumulator in units of 1/48000 of a score point
    localparam int ACC_W     = 23;
    localparam int ACC_ONE   = 48000;
    localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(100 * ACC_ONE);

    // Rounded division by ACC_ONE through a reciprocal multiply
    localparam int NUM_W     = ACC_W + SCORE_FRAC_BITS;
    localparam int RCP_SHIFT = NUM_W + 16;
    localparam int RCP_W     = NUM_W + 1;
    localparam int PROD_W    = NUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_MULT =
        RCP_W'(((64'd1 << RCP_SHIFT) + 64'(ACC_ONE - 1)) / 64'(ACC_ONE));
    localparam logic [NUM_W-1:0] RND_HALF = NUM_W'(ACC_ONE / 2);

    // PM2.5 segments
    localparam logic [PM_W-1:0] PMF_KNEE1 = PM_W'(560);
    localparam logic [PM_W-1:0] PMF_KNEE2 = PM_W'(1200);
    localparam logic [PM_W-1:0] PMF_KNEE3 = PM_W'(2400);
    localparam logic [ACC_W-1:0] PMF_BASE2 = ACC_W'(25 * ACC_ONE);
    localparam logic [ACC_W-1:0] PMF_BASE3 = ACC_W'(50 * ACC_ONE);
    localparam logic [ACC_W-1:0] PMF_CAP   = ACC_W'(75 * ACC_ONE);
    localparam logic [11:0] PMF_SLOPE1 = 12'd2142;
    localparam logic [11:0] PMF_SLOPE2 = 12'd1875;
    localparam logic [11:0] PMF_SLOPE3 = 12'd999;

    // PM10 segments
    localparam logic [PM_W-1:0] PMC_KNEE1 = PM_W'(800);
    localparam logic [PM_W-1:0] PMC_KNEE2 = PM_W'(2400);
    localparam logic [ACC_W-1:0] PMC_BASE2 = ACC_W'(10 * ACC_ONE);
    localparam logic [ACC_W-1:0] PMC_CAP   = ACC_W'(20 * ACC_ONE);
    localparam logic [9:0] PMC_SLOPE1 = 10'd600;
    localparam logic [9:0] PMC_SLOPE2 = 10'd300;

    // VOC segments
    localparam logic [VOC_W-1:0] VOC_KNEE1 = VOC_W'(1280);
    localparam logic [VOC_W-1:0] VOC_KNEE2 = VOC_W'(4800);
    localparam logic [ACC_W-1:0] VOC_BASE2 = ACC_W'(10 * ACC_ONE);
    localparam logic [ACC_W-1:0] VOC_CAP   = ACC_W'(20 * ACC_ONE);
    localparam logic [8:0] VOC_SLOPE1 = 9'd375;
    localparam logic [8:0] VOC_SLOPE2 = 9'd135;

    // Temperature and humidity excess
    localparam logic signed [TEMP_W-1:0] TEMP_KNEE = TEMP_W'(720);
    localparam logic [RH_W-1:0] RH_KNEE = RH_W'(1280);
    localparam logic [9:0] TEMP_SLOPE = 10'd1000;
    localparam logic [9:0] RH_SLOPE   = 10'd750;

    // Anomaly thresholds on slope magnitude
    localparam logic [SLOPE_W:0] SLOPE_SEVERE   = 17'd3000;
    localparam logic [SLOPE_W:0] SLOPE_MODERATE = 17'd1500;
    localparam logic [CUR_W-1:0] OVERLOAD_RESET = CUR_W'(3000);

    // Result codes
    localparam logic [ANOM_W-1:0] ANOM_NONE     = 2'd0;
    localparam logic [ANOM_W-1:0] ANOM_MODERATE = 2'd1;
    localparam logic [ANOM_W-1:0] ANOM_SEVERE   = 2'd2;

    localparam logic [CLASS_W-1:0] CLASS_GOOD      = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_MODERATE  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_POOR      = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_HAZARDOUS = 2'd3;

    // Score thresholds
    localparam logic [SCORE_W-1:0] SC_5  = SCORE_W'(5)  << SCORE_FRAC_BITS;
    localparam logic [SCORE_W-1:0] SC_20 = SCORE_W'(20) << SCORE_FRAC_BITS;
    localparam logic [SCORE_W-1:0] SC_40 = SCORE_W'(40) << SCORE_FRAC_BITS;
    localparam logic [SCORE_W-1:0] SC_50 = SCORE_W'(50) << SCORE_FRAC_BITS;
    localparam logic [SCORE_W-1:0] SC_65 = SCORE_W'(65) << SCORE_FRAC_BITS;
    localparam logic [SCORE_W-1:0] SC_80 = SCORE_W'(80) << SCORE_FRAC_BITS;
    localparam logic [SCORE_W-1:0] SC_85 = SCORE_W'(85) << SCORE_FRAC_BITS;
    localparam logic [SCORE_W-1:0] SC_MAX = SCORE_W'(100) << SCORE_FRAC_BITS;

endpackage

>>> src/apfls_accum.sv
// ----------------------------------------------------------------------------
// apfls_accum
// Piecewise-linear pollution contributions summed and saturated, in units of
// 1/48000 of a score point.
// ----------------------------------------------------------------------------
module apfls_accum
    import apfls_pkg::*;
(
    input  logic [PM_W-1:0]          pm_fine,
    input  logic [PM_W-1:0]          pm_coarse,
    input  logic [VOC_W-1:0]         voc_index,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [RH_W-1:0]          humidity,
    output logic [ACC_W-1:0]         acc
);

    logic [ACC_W-1:0]  pmf_part;
    logic [ACC_W-1:0]  pmc_part;
    logic [ACC_W-1:0]  voc_part;
    logic [ACC_W-1:0]  temp_part;
    logic [ACC_W-1:0]  rh_part;
    logic [TEMP_W-1:0] temp_excess;
    logic [RH_W-1:0]   rh_excess;
    logic [ACC_W+2:0]  sum;

    always_comb
    begin
        if (pm_fine < PMF_KNEE1)
        begin
            pmf_part = ACC_W'(pm_fine) * ACC_W'(PMF_SLOPE1);
        end
        else if (pm_fine < PMF_KNEE2)
        begin
            pmf_part = PMF_BASE2 + ACC_W'(pm_fine - PMF_KNEE1) * ACC_W'(PMF_SLOPE2);
        end
        else if (pm_fine < PMF_KNEE3)
        begin
            pmf_part = PMF_BASE3 + ACC_W'(pm_fine - PMF_KNEE2) * ACC_W'(PMF_SLOPE3);
        end
        else
        begin
            pmf_part = PMF_CAP;
        end

        if (pm_coarse < PMC_KNEE1)
        begin
            pmc_part = ACC_W'(pm_coarse) * ACC_W'(PMC_SLOPE1);
        end
        else if (pm_coarse < PMC_KNEE2)
        begin
            pmc_part = PMC_BASE2 + ACC_W'(pm_coarse - PMC_KNEE1) * ACC_W'(PMC_SLOPE2);
        end
        else
        begin
            pmc_part = PMC_CAP;
        end

        if (voc_index < VOC_KNEE1)
        begin
            voc_part = ACC_W'(voc_index) * ACC_W'(VOC_SLOPE1);
        end
        else if (voc_index < VOC_KNEE2)
        begin
            voc_part = VOC_BASE2 + ACC_W'(voc_index - VOC_KNEE1) * ACC_W'(VOC_SLOPE2);
        end
        else
        begin
            voc_part = VOC_CAP;
        end

        // Cold or normal temperatures, negative ones included, add nothing.
        temp_excess = TEMP_W'(temperature - TEMP_KNEE);
        if (temperature > TEMP_KNEE)
        begin
            temp_part = ACC_W'(temp_excess) * ACC_W'(TEMP_SLOPE);
        end
        else
        begin
            temp_part = '0;
        end

        rh_excess = humidity - RH_KNEE;
        if (humidity > RH_KNEE)
        begin
            rh_part = ACC_W'(rh_excess) * ACC_W'(RH_SLOPE);
        end
        else
        begin
            rh_part = '0;
        end

        sum = (ACC_W+3)'(pmf_part) + (ACC_W+3)'(pmc_part) + (ACC_W+3)'(voc_part)
            + (ACC_W+3)'(temp_part) + (ACC_W+3)'(rh_part);

        if (sum > (ACC_W+3)'(ACC_MAX))
        begin
            acc = ACC_MAX;
        end
        else
        begin
            acc = sum[ACC_W-1:0];
        end
    end

endmodule

>>> src/air_pollution_fan_level_scorer_unit.sv
// ----------------------------------------------------------------------------
// air_pollution_fan_level_scorer_unit
// Scores one fused sensor sample into fan speed, air class, anomaly level
// and a saturated pollution score.
// ----------------------------------------------------------------------------
// Usage:
//   A sample enters on the in_valid / in_ready channel, one field per port.
//   Each transaction yields exactly one result on out_valid / out_ready.
//   The overload current threshold is written over cfg_valid / cfg_ready,
//   which is always ready; write it only while no sample is in flight.
//   The input transaction loads the input register; when the pipe advances,
//   the accumulator register and then the result register load in turn,
//   and out_valid rises with the result register.
//   Throughput is one sample per cycle unless the receiver stalls; the three
//   stages advance together. The pollution score comes from one reciprocal
//   multiply in the last stage, after the segment sums are registered.
//   When the receiver stalls, the result register holds and in_ready drops
//   in the same cycle, so every stage keeps its contents; nothing is lost.
//   Reset empties the pipeline and sets the threshold to 3000 mA.
// ----------------------------------------------------------------------------
module air_pollution_fan_level_scorer_unit
    import apfls_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CUR_W-1:0]           overload_current_ma,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [PM_W-1:0]            pm_fine,
    input  logic [PM_W-1:0]            pm_coarse,
    input  logic [VOC_W-1:0]           voc_index,
    input  logic signed [TEMP_W-1:0]   temperature,
    input  logic [RH_W-1:0]            humidity,
    input  logic [CUR_W-1:0]           motor_current_ma,
    input  logic signed [SLOPE_W-1:0]  current_slope,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [FAN_W-1:0]           fan_speed,
    output logic [CLASS_W-1:0]         air_class,
    output logic [ANOM_W-1:0]          anomaly_level,
    output logic [SCORE_OUT_W-1:0]     smog_score
);

    logic                       advance;

    logic [CUR_W-1:0]           ovl_reg;

    // The first stage holds the registered sample.
    logic                       v1_reg;
    logic [PM_W-1:0]            pmf_reg;
    logic [PM_W-1:0]            pmc_reg;
    logic [VOC_W-1:0]           voc_reg;
    logic signed [TEMP_W-1:0]   temp_reg;
    logic [RH_W-1:0]            rh_reg;
    logic [CUR_W-1:0]           cur_reg;
    logic signed [SLOPE_W-1:0]  slope_reg;

    // The second stage holds the accumulator and the anomaly level.
    logic                       v2_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [ACC_W-1:0]           acc_next;
    logic [ANOM_W-1:0]          anom_reg;
    logic [ANOM_W-1:0]          anom_next;
    logic [SLOPE_W:0]           slope_mag;

    // The third stage holds the result.
    logic                       out_valid_reg;
    logic [SCORE_W-1:0]         score_reg;
    logic [SCORE_W-1:0]         score_next;
    logic [FAN_W-1:0]           fan_reg;
    logic [FAN_W-1:0]           fan_next;
    logic [CLASS_W-1:0]         class_reg;
    logic [CLASS_W-1:0]         class_next;
    logic [ANOM_W-1:0]          anom_out_reg;
    logic [NUM_W-1:0]           numer;
    logic [PROD_W-1:0]          prod;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovl_reg <= OVERLOAD_RESET;
        end
        else if (cfg_valid)
        begin
            ovl_reg <= overload_current_ma;
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pmf_reg      <= pm_fine;
            pmc_reg      <= pm_coarse;
            voc_reg      <= voc_index;
            temp_reg     <= temperature;
            rh_reg       <= humidity;
            cur_reg      <= motor_current_ma;
            slope_reg    <= current_slope;
            acc_reg      <= acc_next;
            anom_reg     <= anom_next;
            score_reg    <= score_next;
            fan_reg      <= fan_next;
            class_reg    <= class_next;
            anom_out_reg <= anom_reg;
        end
    end

    apfls_accum u_accum
    (
        .pm_fine     (pmf_reg),
        .pm_coarse   (pmc_reg),
        .voc_index   (voc_reg),
        .temperature (temp_reg),
        .humidity    (rh_reg),
        .acc         (acc_next)
    );

    always_comb
    begin
        if (slope_reg[SLOPE_W-1])
        begin
            slope_mag = -{slope_reg[SLOPE_W-1], slope_reg};
        end
        else
        begin
            slope_mag = {1'b0, slope_reg};
        end

        if (slope_mag > SLOPE_SEVERE || cur_reg > ovl_reg)
        begin
            anom_next = ANOM_SEVERE;
        end
        else if (slope_mag > SLOPE_MODERATE)
        begin
            anom_next = ANOM_MODERATE;
        end
        else
        begin
            anom_next = ANOM_NONE;
        end
    end

    // Rounded score: (acc * 2^frac + 24000) / 48000, exact through the
    // reciprocal since its error stays below one part in 2^16.
    always_comb
    begin
        numer      = (NUM_W'(acc_reg) << SCORE_FRAC_BITS) + RND_HALF;
        prod       = PROD_W'(numer) * PROD_W'(RCP_MULT);
        score_next = prod[RCP_SHIFT +: SCORE_W];

        priority if (score_next < SC_5)  fan_next = FAN_W'(0);
        else if (score_next < SC_20)     fan_next = FAN_W'(1);
        else if (score_next < SC_40)     fan_next = FAN_W'(2);
        else if (score_next < SC_65)     fan_next = FAN_W'(3);
        else if (score_next < SC_85)     fan_next = FAN_W'(4);
        else                             fan_next = FAN_W'(5);

        priority if (score_next < SC_20) class_next = CLASS_GOOD;
        else if (score_next < SC_50)     class_next = CLASS_MODERATE;
        else if (score_next < SC_80)     class_next = CLASS_POOR;
        else                             class_next = CLASS_HAZARDOUS;
    end

    assign out_valid     = out_valid_reg;
    assign fan_speed     = fan_reg;
    assign air_class     = class_reg;
    assign anomaly_level = anom_out_reg;
    assign smog_score    = SCORE_OUT_W'(score_reg);

    // The saturated accumulator never yields a score above full scale.
    a_score_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> score_reg <= SC_MAX)
        else $error("pollution score above full scale");

    // A hazardous class always comes with one of the two top fan speeds.
    a_class_fan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && air_class == CLASS_HAZARDOUS |-> fan_speed >= FAN_W'(4))
        else $error("hazardous class with low fan speed");

    // A sample in the accumulator stage reaches the output when the pipe moves.
    a_pipe_move: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && in_ready |=> out_valid)
        else $error("accumulated sample lost before output");

    // The anomaly code never takes the unused value.
    a_anom_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> anomaly_level != 2'd3)
        else $error("anomaly level out of range");

endmodule
